>>> src/ttcw_pkg.sv
// Shared types and constants for the text terminal cursor writer.
package ttcw_pkg;

   localparam logic [7:0] CODE_CR    = 8'd13;
   localparam logic [7:0] CODE_BS    = 8'd127;
   localparam logic [7:0] CODE_SPACE = 8'd32;

   localparam int unsigned TRIGGER_LEN = 7;
   localparam logic [2:0]  TRIGGER_LAST = 3'(TRIGGER_LEN - 1);

   localparam logic [1:0] CSR_GRID_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_GRID_ROWS    = 2'd1;

   localparam logic [7:0] GRID_COLUMNS_RESET = 8'd39;
   localparam logic [7:0] GRID_ROWS_RESET    = 8'd29;

   typedef struct packed {
      logic [7:0] glyph;
      logic [7:0] cell_column;
      logic [7:0] cell_row;
      logic       rainbow_foreground;
   } draw_type;

   // Letter expected at each matcher position ("rainbow").
   function automatic logic [7:0] trigger_letter(input logic [2:0] pos);
      logic [7:0] letter;
      case (pos)
         3'd0:    letter = 8'h72;
         3'd1:    letter = 8'h61;
         3'd2:    letter = 8'h69;
         3'd3:    letter = 8'h6E;
         3'd4:    letter = 8'h62;
         3'd5:    letter = 8'h6F;
         3'd6:    letter = 8'h77;
         default: letter = 8'h00;
      endcase
      return letter;
   endfunction

endpackage

>>> src/text_terminal_cursor_writer.sv
// Cursor tracking and draw command generation for a bordered text display.
//
//  Channel  Direction  Handshake            Payload
//  req_     in         req_valid/req_stall  rx_byte
//  rsp_     out        rsp_valid/rsp_stall  glyph, cell_column, cell_row,
//                                           rainbow_foreground
//  csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle while req_stall is low; its draw command is registered
// in out_ff (skid_ff if rsp_ stalls). Cursor and matcher update in the accept cycle.
// Results pass through an output register backed by one skid register; req_stall
// rises only while the skid register holds a result.
// Carriage return yields no draw command. Reset is synchronous; csr_ is always ready.
module text_terminal_cursor_writer
   import ttcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_glyph,
   output logic [7:0] rsp_cell_column,
   output logic [7:0] rsp_cell_row,
   output logic       rsp_rainbow_foreground,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0] grid_columns_ff, grid_rows_ff;
   logic [7:0] column_ff, row_ff, column_in, row_in;
   logic [2:0] trigger_ff, trigger_in;
   logic       rainbow_ff, rainbow_in;
   logic       out_valid_ff, skid_valid_ff;
   draw_type   out_ff, skid_ff, draw_in;

   logic req_accept, is_cr, is_bs, produce, out_take;
   logic [7:0] col_a, row_a;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign is_cr      = (req_rx_byte == CODE_CR);
   assign is_bs      = (req_rx_byte == CODE_BS);
   assign produce    = req_accept && !is_cr;
   assign out_take   = out_valid_ff && !rsp_stall;

   always_comb begin
      col_a = column_ff;
      row_a = row_ff;
      draw_in.glyph              = req_rx_byte;
      draw_in.cell_column        = column_ff;
      draw_in.cell_row           = row_ff;
      draw_in.rainbow_foreground = rainbow_ff;
      if (is_cr) begin
         row_a = row_ff + 8'd1;
         col_a = 8'd1;
      end else if (is_bs) begin
         col_a = column_ff - 8'd1;
         if (col_a == 8'd0) begin
            col_a = grid_columns_ff - 8'd1;
            row_a = row_ff - 8'd1;
         end
         if (row_a == 8'd0) begin
            row_a = grid_rows_ff - 8'd1;
         end
         draw_in.glyph       = CODE_SPACE;
         draw_in.cell_column = col_a;
         draw_in.cell_row    = row_a;
      end else begin
         col_a = column_ff + 8'd1;
      end
      // wrap at the border
      column_in = col_a;
      row_in    = row_a;
      if (col_a >= grid_columns_ff) begin
         row_in    = row_a + 8'd1;
         column_in = 8'd1;
      end
      if (row_in >= grid_rows_ff) begin
         row_in = 8'd1;
      end
   end

   // naive matcher: drop to start on any mismatch
   always_comb begin
      trigger_in = 3'd0;
      rainbow_in = rainbow_ff;
      if (req_rx_byte == trigger_letter(trigger_ff)) begin
         if (trigger_ff == TRIGGER_LAST) begin
            rainbow_in = !rainbow_ff;
         end else begin
            trigger_in = trigger_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= GRID_COLUMNS_RESET;
         grid_rows_ff    <= GRID_ROWS_RESET;
         column_ff       <= 8'd1;
         row_ff          <= 8'd1;
         trigger_ff      <= 3'd0;
         rainbow_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_COLUMNS: grid_columns_ff <= csr_wdata;
               CSR_GRID_ROWS:    grid_rows_ff    <= csr_wdata;
               default:          ;
            endcase
         end
         if (req_accept) begin
            column_ff  <= column_in;
            row_ff     <= row_in;
            trigger_ff <= trigger_in;
            rainbow_ff <= rainbow_in;
         end
         if (!out_valid_ff || out_take) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= produce;
               if (produce) begin
                  out_ff <= draw_in;
               end
            end
         end else if (produce) begin
            // hold the stalled result, park the new one
            skid_ff       <= draw_in;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_glyph              = out_ff.glyph;
   assign rsp_cell_column        = out_ff.cell_column;
   assign rsp_cell_row           = out_ff.cell_row;
   assign rsp_rainbow_foreground = out_ff.rainbow_foreground;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_trigger_range: assert property (@(posedge clock) disable iff (reset)
      trigger_ff != 3'd7)
      else $error("matcher position beyond word length");

   a_draw_emitted: assert property (@(posedge clock) disable iff (reset)
      (produce && !out_valid_ff) |=> rsp_valid)
      else $error("draw command lost");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid filled without output stall");

endmodule
